// ===== hw/rtl/dsa_sign_and_verify_unit_macros.svh =====
// Assertion macros for the DSA sign and verify unit.
// Used by dsa_sign_and_verify_unit; needs clk and rst_n in scope.
`ifndef DSA_SIGN_AND_VERIFY_UNIT_MACROS_SVH
`define DSA_SIGN_AND_VERIFY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DSA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsa assertion failed");
`define DSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsa assertion failed");
`else
`define DSA_ASSERT_SAME(label, ante, cons)
`define DSA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/dsa_pkg.sv =====
// Shared types and constants of the DSA sign and verify unit.
// No dependencies; used by dsa_alu and dsa_sign_and_verify_unit.
`default_nettype none
package dsa_pkg;

    localparam int DSA_WORD_BITS = 32;

    localparam logic [31:0] PRIME_RESET     = 32'd23;
    localparam logic [31:0] ORDER_RESET     = 32'd11;
    localparam logic [31:0] GENERATOR_RESET = 32'd2;
    localparam logic [31:0] SECRET_RESET    = 32'd3;
    localparam logic [31:0] NONCE_RESET     = 32'd7;

    localparam logic [2:0] CFG_PRIME     = 3'd0;
    localparam logic [2:0] CFG_ORDER     = 3'd1;
    localparam logic [2:0] CFG_GENERATOR = 3'd2;
    localparam logic [2:0] CFG_SECRET    = 3'd3;
    localparam logic [2:0] CFG_NONCE     = 3'd4;

    typedef enum logic {
        ALU_MULMOD,
        ALU_DIVMOD
    } alu_op_t;

    typedef struct packed {
        logic    go;
        alu_op_t op;
    } alu_cmd_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_ALU,
        ST_GCD_LOOP,
        ST_GCD_STEP,
        ST_R_RED,
        ST_HQ,
        ST_XR,
        ST_T,
        ST_S_MUL,
        ST_S_SET,
        ST_Y_SET,
        ST_U1,
        ST_U2,
        ST_V1,
        ST_V2,
        ST_VM,
        ST_VR,
        ST_FIN,
        ST_P_INIT,
        ST_P_BASE,
        ST_P_LOOP,
        ST_P_ACC,
        ST_P_SQ,
        ST_P_SQD,
        ST_I_INIT,
        ST_I_R1,
        ST_I_LOOP,
        ST_I_QQ,
        ST_I_NT
    } dsa_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dsa_alu.sv =====
// Shared iterative unit: modular multiply (double-and-add) and restoring divide.
// Depends on dsa_pkg.
`default_nettype none
module dsa_alu #(
    parameter int WORD_BITS = dsa_pkg::DSA_WORD_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dsa_pkg::alu_cmd_t    cmd,
    input  wire logic [WORD_BITS-1:0] a,
    input  wire logic [WORD_BITS-1:0] b,
    input  wire logic [WORD_BITS-1:0] m,
    output logic                      done,
    output logic [WORD_BITS-1:0]      res,
    output logic [WORD_BITS-1:0]      quo
);
    import dsa_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(WORD_BITS);

    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  m_reg, m_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W:0]    acc_reg, acc_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          busy_reg, busy_next;
    logic          add_reg, add_next;
    logic          done_reg, done_next;
    alu_op_t       op_reg, op_next;

    logic [W:0] opnd;
    logic [W:0] diff;
    logic [W:0] sel;
    logic       ge;

    always_comb
    begin
        if (op_reg == ALU_MULMOD)
        begin
            opnd = acc_reg + (add_reg ? {1'b0, a_reg} : acc_reg);
        end
        else
        begin
            opnd = {acc_reg[W-1:0], quo_reg[W-1]};
        end
        ge   = (opnd >= {1'b0, m_reg});
        diff = opnd - {1'b0, m_reg};
        sel  = ge ? diff : opnd;
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        quo_next  = quo_reg;
        acc_next  = acc_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        add_next  = add_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        if (cmd.go)
        begin
            a_next    = a;
            b_next    = b;
            m_next    = m;
            op_next   = cmd.op;
            quo_next  = a;
            acc_next  = '0;
            idx_next  = CW'(W - 1);
            add_next  = 1'b0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                ALU_DIVMOD:
                begin
                    acc_next = sel;
                    quo_next = {quo_reg[W-2:0], ge};
                    idx_next = idx_reg - CW'(1);
                    if (idx_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                ALU_MULMOD:
                begin
                    if (!add_reg)
                    begin
                        acc_next = sel;
                        add_next = 1'b1;
                    end
                    else
                    begin
                        if (b_reg[idx_reg])
                        begin
                            acc_next = sel;
                        end
                        add_next = 1'b0;
                        idx_next = idx_reg - CW'(1);
                        if (idx_reg == '0)
                        begin
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            add_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_MULMOD;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            add_reg  <= add_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        quo_reg <= quo_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign res  = (m_reg == '0) ? '0 : acc_reg[W-1:0];
    assign quo  = quo_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/dsa_sign_and_verify_unit.sv =====
// Top level of the DSA sign and verify unit: sequencer around one shared unit.
// Depends on dsa_pkg, dsa_alu and dsa_sign_and_verify_unit_macros.svh.
//
//   channel   handshake               payload
//   input     start / busy            message_hash
//   result    done (strobe)           sig_r, sig_s, sig_valid
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One transaction runs from start to done as a chain of modular multiplies and
// divisions on the shared unit: the nonce search, four exponentiations and two
// inverses chain them.
// busy stays high until done; rst_n clears the sequencer and loads reset values.
// done lasts one cycle and the receiver cannot stall it.
`default_nettype none
`include "dsa_sign_and_verify_unit_macros.svh"
module dsa_sign_and_verify_unit #(
    parameter int WORD_BITS = dsa_pkg::DSA_WORD_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] message_hash,
    output logic             done,
    output logic [31:0]      sig_r,
    output logic [31:0]      sig_s,
    output logic             sig_valid,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import dsa_pkg::*;

    localparam int W = WORD_BITS;

    logic [W-1:0] p_reg, q_reg, g_reg, x_reg, n_reg;
    logic [W-1:0] h_reg, h_next, k_reg, k_next;
    logic [W-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [W-1:0] t0_reg, t0_next, t1_reg, t1_next;
    logic [W-1:0] nr_reg, nr_next, inv_reg, inv_next;
    logic [W-1:0] r_reg, r_next, hq_reg, hq_next, t_reg, t_next;
    logic [W-1:0] s_reg, s_next, y_reg, y_next;
    logic [W-1:0] u1_reg, u1_next, u2_reg, u2_next, v1_reg, v1_next;
    logic [W-1:0] pa_reg, pa_next, pb_reg, pb_next, pe_reg, pe_next;
    logic         valid_reg, valid_next;
    logic         done_reg, done_next;
    dsa_state_t   state_reg, state_next;
    dsa_state_t   alu_ret_reg, alu_ret_next;
    dsa_state_t   pow_ret_reg, pow_ret_next;
    dsa_state_t   inv_ret_reg, inv_ret_next;

    alu_cmd_t     alu_cmd;
    logic [W-1:0] alu_a, alu_b, alu_m, alu_res, alu_quo;
    logic         alu_done;
    logic [W:0]   tsum;

    dsa_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (alu_cmd),
        .a     (alu_a),
        .b     (alu_b),
        .m     (alu_m),
        .done  (alu_done),
        .res   (alu_res),
        .quo   (alu_quo)
    );

    assign tsum = {1'b0, hq_reg} + {1'b0, alu_res};

    always_comb
    begin
        state_next   = state_reg;
        alu_ret_next = alu_ret_reg;
        pow_ret_next = pow_ret_reg;
        inv_ret_next = inv_ret_reg;
        h_next   = h_reg;
        k_next   = k_reg;
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        t0_next  = t0_reg;
        t1_next  = t1_reg;
        nr_next  = nr_reg;
        inv_next = inv_reg;
        r_next   = r_reg;
        hq_next  = hq_reg;
        t_next   = t_reg;
        s_next   = s_reg;
        y_next   = y_reg;
        u1_next  = u1_reg;
        u2_next  = u2_reg;
        v1_next  = v1_reg;
        pa_next  = pa_reg;
        pb_next  = pb_reg;
        pe_next  = pe_reg;
        valid_next = valid_reg;
        done_next  = 1'b0;
        alu_cmd.go = 1'b0;
        alu_cmd.op = ALU_DIVMOD;
        alu_a = r0_reg;
        alu_b = r1_reg;
        alu_m = q_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    h_next = W'(message_hash);
                    k_next = n_reg;
                    if (q_reg != '0)
                    begin
                        r0_next    = n_reg;
                        r1_next    = q_reg;
                        state_next = ST_GCD_LOOP;
                    end
                    else
                    begin
                        pb_next      = g_reg;
                        pe_next      = n_reg;
                        pow_ret_next = ST_R_RED;
                        state_next   = ST_P_INIT;
                    end
                end
            end
            ST_ALU:
            begin
                if (alu_done)
                begin
                    state_next = alu_ret_reg;
                end
            end
            ST_GCD_LOOP:
            begin
                if (r1_reg == '0)
                begin
                    if (r0_reg == W'(1))
                    begin
                        pb_next      = g_reg;
                        pe_next      = k_reg;
                        pow_ret_next = ST_R_RED;
                        state_next   = ST_P_INIT;
                    end
                    else
                    begin
                        k_next  = k_reg + W'(1);
                        r0_next = k_reg + W'(1);
                        r1_next = q_reg;
                    end
                end
                else
                begin
                    alu_cmd.go   = 1'b1;
                    alu_a        = r0_reg;
                    alu_m        = r1_reg;
                    alu_ret_next = ST_GCD_STEP;
                    state_next   = ST_ALU;
                end
            end
            ST_GCD_STEP:
            begin
                r0_next    = r1_reg;
                r1_next    = alu_res;
                state_next = ST_GCD_LOOP;
            end
            ST_R_RED:
            begin
                alu_cmd.go   = 1'b1;
                alu_a        = pa_reg;
                alu_m        = q_reg;
                alu_ret_next = ST_HQ;
                state_next   = ST_ALU;
            end
            ST_HQ:
            begin
                r_next       = alu_res;
                alu_cmd.go   = 1'b1;
                alu_a        = h_reg;
                alu_m        = q_reg;
                alu_ret_next = ST_XR;
                state_next   = ST_ALU;
            end
            ST_XR:
            begin
                hq_next      = alu_res;
                alu_cmd.go   = 1'b1;
                alu_cmd.op   = ALU_MULMOD;
                alu_a        = r_reg;
                alu_b        = x_reg;
                alu_m        = q_reg;
                alu_ret_next = ST_T;
                state_next   = ST_ALU;
            end
            ST_T:
            begin
                t_next       = (tsum >= {1'b0, q_reg}) ? W'(tsum - {1'b0, q_reg})
                                                       : W'(tsum);
                r1_next      = k_reg;
                inv_ret_next = ST_S_MUL;
                state_next   = ST_I_INIT;
            end
            ST_S_MUL:
            begin
                alu_cmd.go   = 1'b1;
                alu_cmd.op   = ALU_MULMOD;
                alu_a        = inv_reg;
                alu_b        = t_reg;
                alu_m        = q_reg;
                alu_ret_next = ST_S_SET;
                state_next   = ST_ALU;
            end
            ST_S_SET:
            begin
                s_next       = alu_res;
                pb_next      = g_reg;
                pe_next      = x_reg;
                pow_ret_next = ST_Y_SET;
                state_next   = ST_P_INIT;
            end
            ST_Y_SET:
            begin
                y_next       = pa_reg;
                r1_next      = s_reg;
                inv_ret_next = ST_U1;
                state_next   = ST_I_INIT;
            end
            ST_U1:
            begin
                alu_cmd.go   = 1'b1;
                alu_cmd.op   = ALU_MULMOD;
                alu_a        = inv_reg;
                alu_b        = h_reg;
                alu_m        = q_reg;
                alu_ret_next = ST_U2;
                state_next   = ST_ALU;
            end
            ST_U2:
            begin
                u1_next      = alu_res;
                alu_cmd.go   = 1'b1;
                alu_cmd.op   = ALU_MULMOD;
                alu_a        = inv_reg;
                alu_b        = r_reg;
                alu_m        = q_reg;
                alu_ret_next = ST_V1;
                state_next   = ST_ALU;
            end
            ST_V1:
            begin
                u2_next      = alu_res;
                pb_next      = g_reg;
                pe_next      = u1_reg;
                pow_ret_next = ST_V2;
                state_next   = ST_P_INIT;
            end
            ST_V2:
            begin
                v1_next      = pa_reg;
                pb_next      = y_reg;
                pe_next      = u2_reg;
                pow_ret_next = ST_VM;
                state_next   = ST_P_INIT;
            end
            ST_VM:
            begin
                alu_cmd.go   = 1'b1;
                alu_cmd.op   = ALU_MULMOD;
                alu_a        = v1_reg;
                alu_b        = pa_reg;
                alu_m        = p_reg;
                alu_ret_next = ST_VR;
                state_next   = ST_ALU;
            end
            ST_VR:
            begin
                alu_cmd.go   = 1'b1;
                alu_a        = alu_res;
                alu_m        = q_reg;
                alu_ret_next = ST_FIN;
                state_next   = ST_ALU;
            end
            ST_FIN:
            begin
                valid_next = (alu_res == r_reg);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_P_INIT:
            begin
                pa_next      = (p_reg > W'(1)) ? W'(1) : '0;
                alu_cmd.go   = 1'b1;
                alu_a        = pb_reg;
                alu_m        = p_reg;
                alu_ret_next = ST_P_BASE;
                state_next   = ST_ALU;
            end
            ST_P_BASE:
            begin
                pb_next    = alu_res;
                state_next = ST_P_LOOP;
            end
            ST_P_LOOP:
            begin
                if (pe_reg == '0)
                begin
                    state_next = pow_ret_reg;
                end
                else if (pe_reg[0])
                begin
                    alu_cmd.go   = 1'b1;
                    alu_cmd.op   = ALU_MULMOD;
                    alu_a        = pa_reg;
                    alu_b        = pb_reg;
                    alu_m        = p_reg;
                    alu_ret_next = ST_P_ACC;
                    state_next   = ST_ALU;
                end
                else
                begin
                    state_next = ST_P_SQ;
                end
            end
            ST_P_ACC:
            begin
                pa_next    = alu_res;
                state_next = ST_P_SQ;
            end
            ST_P_SQ:
            begin
                alu_cmd.go   = 1'b1;
                alu_cmd.op   = ALU_MULMOD;
                alu_a        = pb_reg;
                alu_b        = pb_reg;
                alu_m        = p_reg;
                alu_ret_next = ST_P_SQD;
                state_next   = ST_ALU;
            end
            ST_P_SQD:
            begin
                pb_next    = alu_res;
                pe_next    = pe_reg >> 1;
                state_next = ST_P_LOOP;
            end
            ST_I_INIT:
            begin
                if (q_reg <= W'(1))
                begin
                    inv_next   = '0;
                    state_next = inv_ret_reg;
                end
                else
                begin
                    r0_next      = q_reg;
                    t0_next      = '0;
                    t1_next      = W'(1);
                    alu_cmd.go   = 1'b1;
                    alu_a        = r1_reg;
                    alu_m        = q_reg;
                    alu_ret_next = ST_I_R1;
                    state_next   = ST_ALU;
                end
            end
            ST_I_R1:
            begin
                r1_next    = alu_res;
                state_next = ST_I_LOOP;
            end
            ST_I_LOOP:
            begin
                if (r1_reg == '0)
                begin
                    inv_next   = (r0_reg == W'(1)) ? t0_reg : W'(1);
                    state_next = inv_ret_reg;
                end
                else
                begin
                    alu_cmd.go   = 1'b1;
                    alu_a        = r0_reg;
                    alu_m        = r1_reg;
                    alu_ret_next = ST_I_QQ;
                    state_next   = ST_ALU;
                end
            end
            ST_I_QQ:
            begin
                nr_next      = alu_res;
                alu_cmd.go   = 1'b1;
                alu_cmd.op   = ALU_MULMOD;
                alu_a        = t1_reg;
                alu_b        = alu_quo;
                alu_m        = q_reg;
                alu_ret_next = ST_I_NT;
                state_next   = ST_ALU;
            end
            ST_I_NT:
            begin
                t1_next    = (t0_reg >= alu_res) ? t0_reg - alu_res
                                                 : t0_reg + (q_reg - alu_res);
                t0_next    = t1_reg;
                r0_next    = r1_reg;
                r1_next    = nr_reg;
                state_next = ST_I_LOOP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            alu_ret_reg <= ST_IDLE;
            pow_ret_reg <= ST_IDLE;
            inv_ret_reg <= ST_IDLE;
            done_reg    <= 1'b0;
            p_reg       <= W'(PRIME_RESET);
            q_reg       <= W'(ORDER_RESET);
            g_reg       <= W'(GENERATOR_RESET);
            x_reg       <= W'(SECRET_RESET);
            n_reg       <= W'(NONCE_RESET);
        end
        else
        begin
            state_reg   <= state_next;
            alu_ret_reg <= alu_ret_next;
            pow_ret_reg <= pow_ret_next;
            inv_ret_reg <= inv_ret_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PRIME:     p_reg <= W'(cfg_data);
                    CFG_ORDER:     q_reg <= W'(cfg_data);
                    CFG_GENERATOR: g_reg <= W'(cfg_data);
                    CFG_SECRET:    x_reg <= W'(cfg_data);
                    CFG_NONCE:     n_reg <= W'(cfg_data);
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg     <= h_next;
        k_reg     <= k_next;
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        nr_reg    <= nr_next;
        inv_reg   <= inv_next;
        r_reg     <= r_next;
        hq_reg    <= hq_next;
        t_reg     <= t_next;
        s_reg     <= s_next;
        y_reg     <= y_next;
        u1_reg    <= u1_next;
        u2_reg    <= u2_next;
        v1_reg    <= v1_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        pe_reg    <= pe_next;
        valid_reg <= valid_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign sig_r     = 32'(r_reg);
    assign sig_s     = 32'(s_reg);
    assign sig_valid = valid_reg;

    `DSA_ASSERT_SAME(a_done_idle, done, !busy)
    `DSA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `DSA_ASSERT_NEXT(a_done_pulse, done, !done)
    `DSA_ASSERT_SAME(a_alu_quiet, alu_cmd.go, state_reg != ST_ALU && state_reg != ST_IDLE)

endmodule
`default_nettype wire
